// File: rtl/core/parameter_schedule_evaluator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the parameter schedule evaluator
// ---------------------------------------------------------------------------
`ifndef PARAMETER_SCHEDULE_EVALUATOR_DEFINES_SVH
`define PARAMETER_SCHEDULE_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSEV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PSEV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/psev_pkg.sv
// ---------------------------------------------------------------------------
// psev_pkg
// Shared codes and constants of the parameter schedule evaluator.
// ---------------------------------------------------------------------------
package psev_pkg;

  // schedule modes
  localparam logic [2:0] MODE_CONST     = 3'd0;
  localparam logic [2:0] MODE_LINEAR    = 3'd1;
  localparam logic [2:0] MODE_EXPONENT  = 3'd2;
  localparam logic [2:0] MODE_PARABOLIC = 3'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_START_VAL = 3'd1;
  localparam logic [2:0] REG_END_VAL   = 3'd2;
  localparam logic [2:0] REG_TIME_BEG  = 3'd3;
  localparam logic [2:0] REG_TIME_END  = 3'd4;

  // magnitude bits of a mul-div result; results clamp to 2^60
  localparam int unsigned MAG_W = 61;

  // square-root chain for exp2: c0 = 2.0, ck = floor(sqrt(c(k-1) * 2^30)), Q.30
  function automatic logic [30:0] exp_const(input int unsigned k);
    logic [63:0] c;
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    for (int unsigned j = 1; j <= 16; j++) begin
      if (j <= k) begin
        x = c << 30;
        r = '0;
        b = 64'd1 << 62;
        for (int unsigned n = 0; n < 32; n++) begin
          if (b != '0) begin
            if (x >= r + b) begin
              x = x - (r + b);
              r = (r >> 1) + b;
            end else begin
              r = r >> 1;
            end
            b = b >> 2;
          end
        end
        c = r;
      end
    end
    return c[30:0];
  endfunction

  // entry i holds c(i+1)
  localparam logic [30:0] EXP_C [16] = '{
    exp_const(1),  exp_const(2),  exp_const(3),  exp_const(4),
    exp_const(5),  exp_const(6),  exp_const(7),  exp_const(8),
    exp_const(9),  exp_const(10), exp_const(11), exp_const(12),
    exp_const(13), exp_const(14), exp_const(15), exp_const(16)
  };

endpackage

// File: rtl/core/psev_muldiv.sv
// ---------------------------------------------------------------------------
// psev_muldiv
// Signed trunc(a * b / d) with the magnitude clamped to 2^60: bit-serial
// shift-add multiply followed by a restoring divide, one bit a cycle.
// ---------------------------------------------------------------------------
module psev_muldiv #(
  parameter int unsigned TW = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [psev_pkg::MAG_W:0]   a_i,
  input  logic signed [TW:0]                b_i,
  input  logic signed [TW:0]                d_i,
  output logic                              done_o,
  output logic signed [psev_pkg::MAG_W:0]   res_o
);

  localparam int unsigned MW = psev_pkg::MAG_W;
  localparam int unsigned PW = MW + TW;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam logic [PW-1:0] CAP = PW'(1) << (MW - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]      phase_q;
  logic [CW-1:0]   cnt_q;
  logic [MW-1:0]   am_q;
  logic [TW-1:0]   bm_q;
  logic [TW-1:0]   dm_q;
  logic [PW-1:0]   acc_q;
  logic [TW-1:0]   rem_q;
  logic            neg_q;

  logic [MW:0]     a_abs;
  logic [TW:0]     b_abs;
  logic [TW:0]     d_abs;
  logic [TW:0]     rem_sh;
  logic            ge;
  logic [TW:0]     rem_sub;
  logic [MW-1:0]   mag;

  // operand magnitudes
  assign a_abs = a_i[MW] ? (MW+1)'(-a_i) : a_i;
  assign b_abs = b_i[TW] ? (TW+1)'(-b_i) : b_i;
  assign d_abs = d_i[TW] ? (TW+1)'(-d_i) : d_i;

  // restoring divide step
  assign rem_sh  = {rem_q, acc_q[PW-1]};
  assign ge      = rem_sh >= {1'b0, dm_q};
  assign rem_sub = rem_sh - {1'b0, dm_q};

  // clamp and sign
  assign mag    = (acc_q > CAP) ? CAP[MW-1:0] : acc_q[MW-1:0];
  assign res_o  = neg_q ? (MW+1)'(-{1'b0, mag}) : {1'b0, mag};
  assign done_o = phase_q == PH_DONE;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      am_q    <= '0;
      bm_q    <= '0;
      dm_q    <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            am_q    <= a_abs[MW-1:0];
            bm_q    <= b_abs[TW-1:0];
            dm_q    <= d_abs[TW-1:0];
            neg_q   <= a_i[MW] ^ b_i[TW] ^ d_i[TW];
            acc_q   <= '0;
            cnt_q   <= '0;
            phase_q <= PH_MUL;
          end
        end
        PH_MUL: begin
          acc_q <= (acc_q << 1) + (bm_q[TW-1] ? PW'(am_q) : '0);
          bm_q  <= bm_q << 1;
          if (cnt_q == CW'(TW - 1)) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            phase_q <= PH_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        PH_DIV: begin
          rem_q <= ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
          acc_q <= {acc_q[PW-2:0], ge};
          if (cnt_q == CW'(PW - 1)) begin
            phase_q <= PH_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/parameter_schedule_evaluator.sv
// ---------------------------------------------------------------------------
// parameter_schedule_evaluator
// Scheduled parameter value per time step: constant, linear, exponential,
// parabolic or hold, in signed fixed point with 16 fraction bits.
// ---------------------------------------------------------------------------
//  channel  handshake                  payload
//  cfg      cfg_we_i                   cfg_idx_i, cfg_data_i
//  in       in_valid_i / in_stall_o    time_step_i
//  out      out_valid_o / out_stall_i  param_value_o, fault_o
//
//  One transaction at a time. Linear and parabolic are set by the shared
//  mul-div unit (one pass linear, two parabolic). Exponential adds two
//  leading-one searches, 32 log2 squaring rounds and 16 exp2 rounds on the
//  shared 31x31 multiplier. Reset clears all configuration and the held
//  value. A stalled result does not block the next input transaction; the
//  sequencer waits only to deliver.
// ---------------------------------------------------------------------------
`include "parameter_schedule_evaluator_defines.svh"

module parameter_schedule_evaluator #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [2:0]                            cfg_idx_i,
  input  logic [((VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH)-1:0] cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [TIME_WIDTH-1:0]                 time_step_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]         param_value_o,
  output logic                                  fault_o
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned TW  = TIME_WIDTH;
  localparam int unsigned MW  = psev_pkg::MAG_W;
  localparam int unsigned PBW = $clog2(VW);
  localparam int unsigned LW  = PBW + 18;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic [61:0] HI62 = (62'd1 << (VW - 1)) - 62'd1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_LIN       = 4'd2;
  localparam logic [3:0] S_PAR_A     = 4'd3;
  localparam logic [3:0] S_PAR_GO    = 4'd4;
  localparam logic [3:0] S_PAR_B     = 4'd5;
  localparam logic [3:0] S_NORM      = 4'd6;
  localparam logic [3:0] S_LOG_MUL   = 4'd7;
  localparam logic [3:0] S_LOG_FIX   = 4'd8;
  localparam logic [3:0] S_EXP_GO    = 4'd9;
  localparam logic [3:0] S_EXP_MD    = 4'd10;
  localparam logic [3:0] S_EXP_MUL   = 4'd11;
  localparam logic [3:0] S_EXP_FIX   = 4'd12;
  localparam logic [3:0] S_EXP_SHIFT = 4'd13;
  localparam logic [3:0] S_OUT       = 4'd14;

  // configuration
  logic [2:0]             mode_q;
  logic signed [VW-1:0]   start_q;
  logic signed [VW-1:0]   end_q;
  logic [TW-1:0]          tbeg_q;
  logic [TW-1:0]          tend_q;

  // sequencer and datapath
  logic [3:0]             state_q;
  logic [TW-1:0]          t_q;
  logic signed [VW-1:0]   held_q;
  logic signed [VW-1:0]   res_val_q;
  logic                   res_fault_q;
  logic                   fresh_q;
  logic signed [MW:0]     a_q;
  logic [VW-1:0]          norm_q;
  logic [PBW-1:0]         p_q;
  logic                   which_q;
  logic [30:0]            m_q;
  logic [15:0]            frac_q;
  logic [15:0]            f_q;
  logic [3:0]             cnt_q;
  logic [61:0]            prod_q;
  logic signed [LW-1:0]   ls_q;
  logic signed [LW-1:0]   le_q;
  logic signed [62:0]     l_q;

  // output register
  logic                   out_valid_q;
  logic signed [VW-1:0]   out_value_q;
  logic                   out_fault_q;

  logic                   in_accept;
  logic                   lin_ok;
  logic                   par_ok;
  logic                   exp_ok;
  logic                   md_start;
  logic signed [MW:0]     md_a;
  logic signed [TW:0]     md_b;
  logic signed [TW:0]     md_d;
  logic                   md_done;
  logic signed [MW:0]     md_res;
  logic signed [VW:0]     diff_es;
  logic signed [VW:0]     diff_se;
  logic signed [LW:0]     diff_l;
  logic signed [TW:0]     t_s;
  logic signed [TW:0]     t_m_tbeg;
  logic signed [TW:0]     t_m_tend;
  logic signed [TW:0]     tend_m_tbeg;
  logic signed [TW:0]     tbeg_m_tend;
  logic [VW+30:0]         norm_ext;
  logic [31:0]            sq;
  logic [15:0]            frac_nx;
  logic signed [PBW+1:0]  p_unb;
  logic signed [LW-1:0]   lval;
  logic signed [62:0]     l_d;
  logic [30:0]            mul_b;
  logic signed [47:0]     sh;
  logic signed [47:0]     nsh;
  logic [61:0]            shl;
  logic [61:0]            shr;
  logic [61:0]            exp_raw;
  logic signed [VW-1:0]   exp_val;
  logic signed [63:0]     lin_sum;
  logic signed [63:0]     par_sum;
  logic signed [VW-1:0]   lin_val;
  logic signed [VW-1:0]   par_val;

  assign in_stall_o    = state_q != S_IDLE;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign param_value_o = out_value_q;
  assign fault_o       = out_fault_q;

  // special cases
  assign lin_ok = tend_q != tbeg_q;
  assign par_ok = tend_q != '0;
  assign exp_ok = lin_ok && (start_q > 0) && (end_q > 0);

  // operand differences
  assign diff_es     = (VW+1)'(end_q) - (VW+1)'(start_q);
  assign diff_se     = (VW+1)'(start_q) - (VW+1)'(end_q);
  assign diff_l      = (LW+1)'(ls_q) - (LW+1)'(le_q);
  assign t_s         = {1'b0, t_q};
  assign t_m_tbeg    = {1'b0, t_q} - {1'b0, tbeg_q};
  assign t_m_tend    = {1'b0, t_q} - {1'b0, tend_q};
  assign tend_m_tbeg = {1'b0, tend_q} - {1'b0, tbeg_q};
  assign tbeg_m_tend = {1'b0, tbeg_q} - {1'b0, tend_q};

  // mul-div operand select
  always_comb begin
    md_start = 1'b0;
    md_a     = (MW+1)'(diff_es);
    md_b     = t_s;
    md_d     = tend_m_tbeg;
    case (state_q)
      S_DISP: begin
        if (mode_q == psev_pkg::MODE_LINEAR) begin
          md_start = lin_ok;
        end else if (mode_q == psev_pkg::MODE_PARABOLIC) begin
          md_start = par_ok;
          md_a     = (MW+1)'(diff_se);
          md_d     = {1'b0, tend_q};
        end
      end
      S_PAR_GO: begin
        md_start = 1'b1;
        md_a     = a_q;
        md_b     = t_m_tend;
        md_d     = {1'b0, tend_q};
      end
      S_EXP_GO: begin
        md_start = 1'b1;
        md_a     = (MW+1)'(diff_l);
        md_b     = t_m_tbeg;
        md_d     = tbeg_m_tend;
      end
      default: begin
        md_start = 1'b0;
      end
    endcase
  end

  psev_muldiv #(
    .TW (TW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  // log2 mantissa and squaring round
  assign norm_ext = {norm_q, 31'b0};
  assign sq       = prod_q[61:30];
  assign frac_nx  = {frac_q[14:0], sq[31]};
  assign p_unb    = (PBW+2)'(p_q) - (PBW+2)'(16);
  assign lval     = {p_unb, frac_nx};
  assign l_d      = 63'(ls_q) + 63'(md_res);

  // shared multiplier operand
  assign mul_b = (state_q == S_EXP_MUL) ? psev_pkg::EXP_C[cnt_q] : m_q;

  // exp2 final scaling
  assign sh  = {l_q[62], l_q[62:16]} - 48'sd14;
  assign nsh = -sh;
  assign shl = {31'b0, m_q} << sh[4:0];
  assign shr = {31'b0, m_q} >> nsh[5:0];
  always_comb begin
    if (!sh[47]) begin
      exp_raw = (sh > 48'sd31) ? HI62 : shl;
    end else begin
      exp_raw = (nsh >= 48'sd64) ? '0 : shr;
    end
    exp_val = (exp_raw > HI62) ? HI62[VW-1:0] : exp_raw[VW-1:0];
  end

  // linear and parabolic sums with saturation
  assign lin_sum = 64'(start_q) + 64'(md_res);
  assign par_sum = 64'(start_q) + 64'(md_res) - 64'(a_q);
  always_comb begin
    if (lin_sum > SAT_HI) begin
      lin_val = SAT_HI[VW-1:0];
    end else if (lin_sum < SAT_LO) begin
      lin_val = SAT_LO[VW-1:0];
    end else begin
      lin_val = lin_sum[VW-1:0];
    end
    if (par_sum > SAT_HI) begin
      par_val = SAT_HI[VW-1:0];
    end else if (par_sum < SAT_LO) begin
      par_val = SAT_LO[VW-1:0];
    end else begin
      par_val = par_sum[VW-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
      tbeg_q  <= '0;
      tend_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psev_pkg::REG_MODE:      mode_q  <= cfg_data_i[2:0];
        psev_pkg::REG_START_VAL: start_q <= cfg_data_i[VW-1:0];
        psev_pkg::REG_END_VAL:   end_q   <= cfg_data_i[VW-1:0];
        psev_pkg::REG_TIME_BEG:  tbeg_q  <= cfg_data_i[TW-1:0];
        psev_pkg::REG_TIME_END:  tend_q  <= cfg_data_i[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_fault_q <= 1'b0;
      t_q         <= '0;
      res_val_q   <= '0;
      res_fault_q <= 1'b0;
      fresh_q     <= 1'b0;
      a_q         <= '0;
      norm_q      <= '0;
      p_q         <= '0;
      which_q     <= 1'b0;
      m_q         <= '0;
      frac_q      <= '0;
      f_q         <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      ls_q        <= '0;
      le_q        <= '0;
      l_q         <= '0;
    end else begin
      // drop a delivered result unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            t_q     <= time_step_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          case (mode_q)
            psev_pkg::MODE_CONST: begin
              res_val_q   <= start_q;
              res_fault_q <= 1'b0;
              fresh_q     <= 1'b1;
              state_q     <= S_OUT;
            end
            psev_pkg::MODE_LINEAR: begin
              res_val_q   <= held_q;
              res_fault_q <= !lin_ok;
              fresh_q     <= 1'b0;
              state_q     <= lin_ok ? S_LIN : S_OUT;
            end
            psev_pkg::MODE_EXPONENT: begin
              res_val_q   <= held_q;
              res_fault_q <= !exp_ok;
              fresh_q     <= 1'b0;
              if (exp_ok) begin
                norm_q  <= start_q;
                p_q     <= PBW'(VW - 1);
                which_q <= 1'b0;
                state_q <= S_NORM;
              end else begin
                state_q <= S_OUT;
              end
            end
            psev_pkg::MODE_PARABOLIC: begin
              res_val_q   <= held_q;
              res_fault_q <= !par_ok;
              fresh_q     <= 1'b0;
              state_q     <= par_ok ? S_PAR_A : S_OUT;
            end
            default: begin
              res_val_q   <= held_q;
              res_fault_q <= 1'b0;
              fresh_q     <= 1'b0;
              state_q     <= S_OUT;
            end
          endcase
        end
        S_LIN: begin
          if (md_done) begin
            res_val_q <= lin_val;
            fresh_q   <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        S_PAR_A: begin
          if (md_done) begin
            a_q     <= md_res;
            state_q <= S_PAR_GO;
          end
        end
        S_PAR_GO: begin
          state_q <= S_PAR_B;
        end
        S_PAR_B: begin
          if (md_done) begin
            res_val_q <= par_val;
            fresh_q   <= 1'b1;
            state_q   <= S_OUT;
          end
        end
        // leading-one search, one bit a cycle
        S_NORM: begin
          if (norm_q[VW-1]) begin
            m_q     <= norm_ext[VW+30:VW];
            cnt_q   <= '0;
            state_q <= S_LOG_MUL;
          end else begin
            norm_q <= norm_q << 1;
            p_q    <= p_q - 1'b1;
          end
        end
        S_LOG_MUL: begin
          prod_q  <= m_q * mul_b;
          state_q <= S_LOG_FIX;
        end
        S_LOG_FIX: begin
          frac_q <= frac_nx;
          m_q    <= sq[31] ? sq[31:1] : sq[30:0];
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == 4'd15) begin
            if (!which_q) begin
              ls_q    <= lval;
              norm_q  <= end_q;
              p_q     <= PBW'(VW - 1);
              which_q <= 1'b1;
              state_q <= S_NORM;
            end else begin
              le_q    <= lval;
              state_q <= S_EXP_GO;
            end
          end else begin
            state_q <= S_LOG_MUL;
          end
        end
        S_EXP_GO: begin
          state_q <= S_EXP_MD;
        end
        S_EXP_MD: begin
          if (md_done) begin
            l_q     <= l_d;
            f_q     <= l_d[15:0];
            m_q     <= 31'd1 << 30;
            cnt_q   <= '0;
            state_q <= S_EXP_MUL;
          end
        end
        S_EXP_MUL: begin
          prod_q  <= m_q * mul_b;
          state_q <= S_EXP_FIX;
        end
        S_EXP_FIX: begin
          if (f_q[15]) begin
            m_q <= prod_q[60:30];
          end
          f_q   <= f_q << 1;
          cnt_q <= cnt_q + 1'b1;
          state_q <= (cnt_q == 4'd15) ? S_EXP_SHIFT : S_EXP_MUL;
        end
        S_EXP_SHIFT: begin
          res_val_q   <= exp_val;
          res_fault_q <= 1'b0;
          fresh_q     <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_val_q;
            out_fault_q <= res_fault_q;
            if (fresh_q) begin
              held_q <= res_val_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `PSEV_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o, "accepted transaction did not start the sequencer")
  `PSEV_ASSERT_IMPL(a_done_in_wait, clk_i, rst_ni, md_done, state_q == S_LIN || state_q == S_PAR_A || state_q == S_PAR_B || state_q == S_EXP_MD, "mul-div finished outside a wait state")
  `PSEV_ASSERT_IMPL(a_fault_holds, clk_i, rst_ni, out_valid_q && out_fault_q, out_value_q == held_q, "faulted result differs from held value")
  `PSEV_ASSERT_IMPL(a_norm_nonzero, clk_i, rst_ni, state_q == S_NORM, norm_q != '0, "leading-one search on zero")

endmodule
